>>> sv/csfw_pkg.sv
// Package for the counting semaphore with waiter queue.
// Holds the status codes, the decision struct and sizing constants.
// No dependencies.
`default_nettype none

package csfw_pkg;

  localparam int MAX_WAITERS_DEF = 64;
  localparam int COUNT_LIMIT     = 255;
  localparam int ID_W            = 8;
  localparam int CNT_OUT_W       = 9;
  localparam int CFG_W           = 8;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_NO_WAITER = 3'd2,
    ST_WOKE      = 3'd3,
    ST_FULL      = 3'd4,
    ST_SATURATED = 3'd5
  } status_t;

  typedef enum logic {
    OP_WAIT   = 1'b0,
    OP_SIGNAL = 1'b1
  } op_t;

  // Outcome of one request, core to top level
  typedef struct packed {
    status_t status;
    logic    woken_valid;
    logic    push;
    logic    pop;
  } decision_t;

endpackage

`default_nettype wire

>>> sv/csfw_if.sv
// Handshake interfaces for the request and result channels.
// Depends on csfw_pkg for field widths.
`default_nettype none

interface csfw_req_if
  import csfw_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            kind;
  logic [ID_W-1:0] requester_id;

  modport source (output valid, kind, requester_id, input ready);
  modport sink   (input valid, kind, requester_id, output ready);
endinterface

interface csfw_res_if
  import csfw_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic                 woken_valid;
  logic [ID_W-1:0]      woken_id;
  logic [CNT_OUT_W-1:0] count_after;

  modport source (output valid, status, woken_valid, woken_id, count_after, input ready);
  modport sink   (input valid, status, woken_valid, woken_id, count_after, output ready);
endinterface

`default_nettype wire

>>> sv/csfw_ring.sv
// Waiter ring storage: one write port, one registered read port.
// Depends on csfw_pkg.
`default_nettype none

module csfw_ring
  import csfw_pkg::*;
#(
  parameter int MAX_WAITERS = MAX_WAITERS_DEF,
  localparam int IW = $clog2(MAX_WAITERS)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [IW-1:0]   wr_addr,
  input  wire logic [ID_W-1:0] wr_data,
  input  wire logic            re,
  input  wire logic [IW-1:0]   rd_addr,
  output logic      [ID_W-1:0] rd_data
);

  logic [ID_W-1:0] mem [MAX_WAITERS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds unless a new pop is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/csfw_core.sv
// Semaphore state: count, ring pointers, waiter total; a config write loads the count only
// with none parked; decides one request's outcome per cycle on step. Depends on csfw_pkg.
`default_nettype none

module csfw_core
  import csfw_pkg::*;
#(
  parameter int MAX_WAITERS = MAX_WAITERS_DEF,
  localparam int IW = $clog2(MAX_WAITERS),
  localparam int TW = $clog2(MAX_WAITERS + 1),
  localparam int CW = ($clog2(MAX_WAITERS) + 2 > CNT_OUT_W) ? $clog2(MAX_WAITERS) + 2
                                                            : CNT_OUT_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_W-1:0]     cfg_wr_data,
  input  wire logic                 step,
  input  wire logic                 kind,
  output decision_t                 dec,
  output logic signed [CW-1:0]      count_new,
  output logic        [IW-1:0]      head,
  output logic        [IW-1:0]      tail
);

  localparam logic signed [CW-1:0] LIMIT_C = CW'(COUNT_LIMIT);
  localparam logic        [TW-1:0] FULL_C  = TW'(MAX_WAITERS);
  localparam logic        [IW-1:0] LAST_C  = IW'(MAX_WAITERS - 1);

  // count spans -MAX_WAITERS..255, with one spare bit so count - 1 stays negative
  logic signed [CW-1:0] count;
  logic        [TW-1:0] total;
  logic signed [CW-1:0] count_dec;
  logic signed [CW-1:0] count_inc;

  assign count_dec = count - CW'(1);
  assign count_inc = count + CW'(1);

  always_comb begin
    dec       = '0;
    dec.status = ST_GRANTED;
    count_new = count;
    if (op_t'(kind) == OP_WAIT) begin
      if (count_dec < 0) begin
        if (total == FULL_C) begin
          dec.status = ST_FULL;
        end else begin
          dec.status = ST_QUEUED;
          dec.push   = 1'b1;
          count_new  = count_dec;
        end
      end else begin
        dec.status = ST_GRANTED;
        count_new  = count_dec;
      end
    end else begin
      if (count >= LIMIT_C) begin
        dec.status = ST_SATURATED;
        count_new  = LIMIT_C;
      end else begin
        count_new = count_inc;
        if (count_inc <= 0 && total != '0) begin
          dec.status      = ST_WOKE;
          dec.pop         = 1'b1;
          dec.woken_valid = 1'b1;
        end else begin
          dec.status = ST_NO_WAITER;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      total         <= '0;
      head          <= '0;
      tail          <= '0;
    end else if (cfg_wr_en) begin
      if (total == '0) begin
        count <= CW'(cfg_wr_data);
      end
    end else if (step) begin
      count <= count_new;
      if (dec.push) begin
        tail  <= (tail == LAST_C) ? '0 : tail + IW'(1);
        total <= total + TW'(1);
      end
      if (dec.pop) begin
        head  <= (head == LAST_C) ? '0 : head + IW'(1);
        total <= total - TW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/counting_semaphore_fifo_waiters_unit.sv
// Top level of the counting semaphore with a first-in first-out waiter queue.
// Depends on csfw_pkg, csfw_if, csfw_core and csfw_ring.
`default_nettype none

// Channel   Dir  Payload                                        Handshake
// req       in   kind, requester_id                             valid/ready
// res       out  status, woken_valid, woken_id, count_after     valid/ready
// cfg       in   cfg_wr_data (initial_count)                    cfg_wr_en
//
// One request per cycle sustained while res.ready holds: input register, then
// result register. The decision and state update sit between those two.
// A pop reads the ring at the head pointer; the read data register is the
// result's woken_id source, so no extra stage is needed.
// rst is synchronous: count, pointers and total clear to zero.
// A held result stalls the input register, which in turn drops req.ready.

module counting_semaphore_fifo_waiters_unit
  import csfw_pkg::*;
#(
  parameter int MAX_WAITERS = MAX_WAITERS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  csfw_req_if.sink              req,
  csfw_res_if.source            res
);

  localparam int IW = $clog2(MAX_WAITERS);
  localparam int CW = ($clog2(MAX_WAITERS) + 2 > CNT_OUT_W) ? $clog2(MAX_WAITERS) + 2
                                                            : CNT_OUT_W;

  // input register
  logic            in_valid;
  logic            in_kind;
  logic [ID_W-1:0] in_id;

  // result register
  logic                 out_valid;
  status_t              out_status;
  logic                 out_woken;
  logic [CNT_OUT_W-1:0] out_count;

  logic                 advance;
  logic                 step;
  decision_t            dec;
  logic signed [CW-1:0] count_new;
  logic [IW-1:0]        head;
  logic [IW-1:0]        tail;
  logic [ID_W-1:0]      rd_data;

  // result slot free or being drained this cycle
  assign advance   = !out_valid || res.ready;
  assign step      = in_valid && advance;
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_kind <= req.kind;
      in_id   <= req.requester_id;
    end
  end

  csfw_core #(
    .MAX_WAITERS (MAX_WAITERS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .kind        (in_kind),
    .dec         (dec),
    .count_new   (count_new),
    .head        (head),
    .tail        (tail)
  );

  // a push and a pop never share a cycle, so no read/write collision
  csfw_ring #(
    .MAX_WAITERS (MAX_WAITERS)
  ) u_ring (
    .clk     (clk),
    .we      (step && dec.push),
    .wr_addr (tail),
    .wr_data (in_id),
    .re      (step && dec.pop),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_status <= dec.status;
      out_woken  <= dec.woken_valid;
      out_count  <= count_new[CNT_OUT_W-1:0];
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_status;
  assign res.woken_valid = out_woken;
  assign res.woken_id    = out_woken ? rd_data : '0;
  assign res.count_after = out_count;

endmodule

`default_nettype wire

>>> tb/counting_semaphore_fifo_waiters_unit_tb.sv
// Testbench for counting_semaphore_fifo_waiters_unit: a directed table, then random bursts,
// checked against a behavioural predictor of the semaphore and its waiter FIFO, or against
// results typed in the table rows. Depends on csfw_pkg, csfw_if and the unit itself.
`timescale 1ns / 100ps

module counting_semaphore_fifo_waiters_unit_tb;
  import csfw_pkg::*;

  localparam int WAITER_DEPTH = MAX_WAITERS_DEF;
  localparam int HOLD_CYCLES  = 150;   // long result-side stall for back-pressure
  localparam int PHASE_ITEMS  = 300;   // random requests per phase, at least (the last burst may run over)

  // One result as the block should present it
  typedef struct packed {
    status_t    status;
    logic       woken_valid;
    logic [7:0] woken_id;
    logic [8:0] count_after;
  } sem_result_t;

  localparam sem_result_t BLANK_RESULT = '0;

  // Directed table rows: a register write, a request checked against the
  // predictor, or a request whose result is typed in the row
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_OP,
    ROW_CHECKED
  } row_kind_t;

  typedef struct packed {
    row_kind_t   what;
    op_t         kind;
    logic [7:0]  id;     // requester id, or register value for ROW_CFG
    logic [7:0]  reps;   // request repeated with id counting up
    sem_result_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  csfw_req_if req_ch ();
  csfw_res_if res_ch ();

  counting_semaphore_fifo_waiters_unit #(
    .MAX_WAITERS(WAITER_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .res        (res_ch)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: the count and the parked requester ids.
  // A queue stands in for the ring; head/tail wrap is invisible from outside.
  // ---------------------------------------------------------------------------
  int         sem_count;
  logic [7:0] parked_ids[$];

  sem_result_t awaited[$];   // results still owed by the block, oldest first
  int mismatch_count;

  int  src_idle_pct;         // chance in 100 of a gap before each request
  int  snk_idle_pct;         // chance in 100 of ready low on a cycle
  bit  hold_ask;             // asks the result side for one long stall

  plan_row_t directed_plan[$];

  // Applies one request to the predictor state and returns its result.
  function automatic sem_result_t apply_semaphore_op(op_t k, logic [7:0] id);
    sem_result_t r;
    r = BLANK_RESULT;
    if (k == OP_WAIT) begin
      if (sem_count - 1 < 0) begin
        // would block: park the id unless the FIFO is already full
        if (parked_ids.size() >= WAITER_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          parked_ids.push_back(id);
          sem_count--;
          r.status = ST_QUEUED;
        end
      end else begin
        sem_count--;
        r.status = ST_GRANTED;
      end
    end else if (sem_count >= COUNT_LIMIT) begin
      // saturated: nothing moves
      sem_count = COUNT_LIMIT;
      r.status  = ST_SATURATED;
    end else begin
      sem_count++;
      if (sem_count <= 0 && parked_ids.size() > 0) begin
        r.woken_id    = parked_ids.pop_front();
        r.woken_valid = 1'b1;
        r.status      = ST_WOKE;
      end else begin
        r.status = ST_NO_WAITER;
      end
    end
    r.count_after = sem_count[8:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Gaps are drawn before each request; the request then stays
  // up until accepted. ready is read straight after the edge, i.e. the value
  // the block presented at that edge.
  // ---------------------------------------------------------------------------
  task automatic offer_request(op_t k, logic [7:0] id, bit use_typed, sem_result_t typed);
    sem_result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= k;
    req_ch.requester_id <= id;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // predictor always advances, even where the row carries its own result
    predicted = apply_semaphore_op(k, id);
    awaited.push_back(use_typed ? typed : predicted);
  endtask

  // Register write, only with the block drained. The pipeline is two deep, and
  // the task waits out every owed result and some spare clocks before the write.
  task automatic write_initial_count(logic [7:0] v);
    req_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    // with waiters parked the count is left alone
    if (parked_ids.size() == 0) sem_count = int'(v);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: checks at each accepting edge, then picks ready for the next.
  // ---------------------------------------------------------------------------
  task automatic compare_field(string fname, logic [8:0] want, logic [8:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    sem_result_t want;
    if (awaited.size() == 0) begin
      $display("%0t: result with no request outstanding, expected none, actual status %0d",
               $time, res_ch.status);
      mismatch_count++;
    end else begin
      want = awaited.pop_front();
      compare_field("status", 9'(want.status), 9'(res_ch.status));
      compare_field("woken_valid", 9'(want.woken_valid), 9'(res_ch.woken_valid));
      compare_field("woken_id", 9'(want.woken_id), 9'(res_ch.woken_id));
      compare_field("count_after", want.count_after, res_ch.count_after);
    end
  endtask

  initial begin : result_side
    int hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) check_result();
      if (hold_ask) begin
        hold_left = HOLD_CYCLES;
        hold_ask  = 1'b0;
      end
      if (hold_left > 0) begin
        // long stall: the request side keeps offering and must get stalled
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t row;
    int        done;
    int        burst_len;
    int        wait_pct;
    int        phase;
    logic [7:0] cfg_pick;

    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= 8'h00;
    req_ch.valid        <= 1'b0;
    req_ch.kind         <= OP_WAIT;
    req_ch.requester_id <= 8'h00;
    mismatch_count = 0;
    hold_ask       = 1'b0;
    src_idle_pct   = 27;
    snk_idle_pct   = 56;

    // predictor reset: count zero, nobody parked
    sem_count      = 0;
    parked_ids.delete();

    // Directed table. From reset the count is zero.
    // wait blocks at zero, signal wakes it, then plain signal and grant
    directed_plan.push_back(plan_row_t'{ROW_CHECKED, OP_WAIT, 8'hA5, 8'd1,
                            sem_result_t'{ST_QUEUED, 1'b0, 8'h00, 9'h1FF}});
    directed_plan.push_back(plan_row_t'{ROW_CHECKED, OP_SIGNAL, 8'h00, 8'd1,
                            sem_result_t'{ST_WOKE, 1'b1, 8'hA5, 9'h000}});
    directed_plan.push_back(plan_row_t'{ROW_CHECKED, OP_SIGNAL, 8'h7E, 8'd1,
                            sem_result_t'{ST_NO_WAITER, 1'b0, 8'h00, 9'h001}});
    directed_plan.push_back(plan_row_t'{ROW_CHECKED, OP_WAIT, 8'h5A, 8'd1,
                            sem_result_t'{ST_GRANTED, 1'b0, 8'h00, 9'h000}});
    // top of the count: load 255, signal saturates
    directed_plan.push_back(plan_row_t'{ROW_CFG, OP_WAIT, 8'hFF, 8'd0, BLANK_RESULT});
    directed_plan.push_back(plan_row_t'{ROW_CHECKED, OP_SIGNAL, 8'h00, 8'd1,
                            sem_result_t'{ST_SATURATED, 1'b0, 8'h00, 9'h0FF}});
    directed_plan.push_back(plan_row_t'{ROW_CHECKED, OP_WAIT, 8'hFF, 8'd1,
                            sem_result_t'{ST_GRANTED, 1'b0, 8'h00, 9'h0FE}});
    directed_plan.push_back(plan_row_t'{ROW_CHECKED, OP_SIGNAL, 8'hFF, 8'd1,
                            sem_result_t'{ST_NO_WAITER, 1'b0, 8'h00, 9'h0FF}});
    // bottom: from zero, fill the waiter FIFO (ids 0x00..0x3F), then one more
    directed_plan.push_back(plan_row_t'{ROW_CFG, OP_WAIT, 8'h00, 8'd0, BLANK_RESULT});
    directed_plan.push_back(plan_row_t'{ROW_OP, OP_WAIT, 8'h00, 8'(WAITER_DEPTH),
                            BLANK_RESULT});
    directed_plan.push_back(plan_row_t'{ROW_CHECKED, OP_WAIT, 8'h80, 8'd1,
                            sem_result_t'{ST_FULL, 1'b0, 8'h00, 9'h1C0}});
    // register write with waiters parked must leave the count at -64
    directed_plan.push_back(plan_row_t'{ROW_CFG, OP_WAIT, 8'hC8, 8'd0, BLANK_RESULT});
    directed_plan.push_back(plan_row_t'{ROW_CHECKED, OP_SIGNAL, 8'h01, 8'd1,
                            sem_result_t'{ST_WOKE, 1'b1, 8'h00, 9'h1C1}});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      case (row.what)
        ROW_CFG: begin
          write_initial_count(row.id);
        end
        default: begin
          for (int n = 0; n < row.reps; n++) begin
            offer_request(row.kind, row.id + 8'(n), row.what == ROW_CHECKED, row.want);
          end
        end
      endcase
    end

    // Random part: bursts leaning to waits, to signals, or even, so the count
    // runs down into a full FIFO and up into saturation. Register writes
    // between bursts, biased to the extremes.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 27;
          snk_idle_pct = 56;
        end
        1: begin
          src_idle_pct = 56;
          snk_idle_pct = 27;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
          hold_ask     = 1'b1;   // back-pressure run, then flat out
        end
      endcase
      done = 0;
      while (done < PHASE_ITEMS) begin
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(3))
            0:       cfg_pick = 8'h00;
            1:       cfg_pick = 8'hFF;
            2:       cfg_pick = 8'hFE;
            default: cfg_pick = 8'($urandom_range(255));
          endcase
          write_initial_count(cfg_pick);
        end
        case ($urandom_range(2))
          0:       wait_pct = 85;
          1:       wait_pct = 15;
          default: wait_pct = 50;
        endcase
        burst_len = $urandom_range(100, 10);
        for (int n = 0; n < burst_len; n++) begin
          offer_request(($urandom_range(99) < wait_pct) ? OP_WAIT : OP_SIGNAL,
                        8'($urandom_range(255)), 1'b0, BLANK_RESULT);
        end
        done += burst_len;
      end
    end

    req_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    // keep the clock running to catch any stray result
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
sv/csfw_pkg.sv
sv/csfw_if.sv
sv/csfw_ring.sv
sv/csfw_core.sv
sv/counting_semaphore_fifo_waiters_unit.sv
tb/counting_semaphore_fifo_waiters_unit_tb.sv
